// File: hdl/string_key_hash_table_unit_assert.svh
// Assertion macros for the string key hash table unit.
// Depends on: a clock named clock and a synchronous reset named reset in the module that uses them.
`ifndef STRING_KEY_HASH_TABLE_UNIT_ASSERT_SVH
`define STRING_KEY_HASH_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication.
`define SKHT_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("skht: same-cycle check failed");
// Next-cycle implication.
`define SKHT_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("skht: next-cycle check failed");
`else
`define SKHT_ASSERT_NOW(label, pre, post)
`define SKHT_ASSERT_NEXT(label, pre, post)
`endif
`endif

// File: hdl/skht_pkg.sv
// Shared types, constants and the hash step function of the string key hash table unit.
// Depends on: nothing.
package skht_pkg;

   // Table geometry.
   localparam int TABLE_SLOTS = 64;
   localparam int KEY_BYTES   = 8;
   localparam int VALUE_WIDTH = 32;

   // Fixed widths of the port fields.
   localparam int OP_W          = 2;
   localparam int KEY_FIELD_BYTES = 8;
   localparam int KEY_FIELD_W   = 64;
   localparam int LEN_FIELD_W   = 4;
   localparam int VALUE_FIELD_W = 32;
   localparam int BYTE_SEL_W    = 3;

   // Derived widths.
   localparam int SLOT_W      = $clog2(TABLE_SLOTS);
   localparam int KEY_W       = (KEY_BYTES - 1) * 8;
   localparam int SLEN_W      = $clog2(KEY_BYTES);
   localparam int STORE_VAL_W = (VALUE_WIDTH < VALUE_FIELD_W) ? VALUE_WIDTH : VALUE_FIELD_W;

   // Hash reduction: the sum h*31 + byte stays below TABLE_SLOTS << HASH_RED_STEPS.
   localparam int HASH_T_W       = $clog2(32 * TABLE_SLOTS + 256) + 1;
   localparam int HASH_RED_STEPS = $clog2((32 * TABLE_SLOTS + 255) / TABLE_SLOTS);

   // Operation codes.
   localparam logic [OP_W-1:0] OP_SET    = 2'd0;
   localparam logic [OP_W-1:0] OP_GET    = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TOO_LONG  = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      IDLE,
      HASH,
      PROBE,
      REPLY
   } state_type;

   // One table entry as held in the slot memory.
   typedef struct packed {
      logic [KEY_W-1:0]       key;
      logic [SLEN_W-1:0]      len;
      logic [STORE_VAL_W-1:0] value;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic hash_step;
      logic probe_start;
      logic probe_eval;
      logic reply_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic skip;
      logic hash_done;
      logic probe_done;
      logic out_free;
   } stat_type;

   // One fold of the hash: (h * 31 + b) mod TABLE_SLOTS, reduced by a short chain of
   // conditional subtractions of shifted copies of the table size.
   function automatic logic [SLOT_W-1:0] hash_step(input logic [SLOT_W-1:0] h,
                                                   input logic [7:0] b);
      logic [HASH_T_W-1:0] t;
      t = (HASH_T_W'(h) << 5) - HASH_T_W'(h) + HASH_T_W'(b);
      for (int k = HASH_RED_STEPS - 1; k >= 0; k--) begin
         if (t >= HASH_T_W'(TABLE_SLOTS << k)) begin
            t = t - HASH_T_W'(TABLE_SLOTS << k);
         end
      end
      return t[SLOT_W-1:0];
   endfunction

endpackage

// File: hdl/skht_ctrl.sv
// Controller state machine of the string key hash table unit.
// Depends on: skht_pkg, string_key_hash_table_unit_assert.svh.
`include "string_key_hash_table_unit_assert.svh"

module skht_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  skht_pkg::stat_type stat,
   output skht_pkg::cmd_type  cmd
);

   skht_pkg::state_type state_ff;
   skht_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= skht_pkg::IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         skht_pkg::IDLE: begin
            if (req_valid) state_in = skht_pkg::HASH;
         end
         skht_pkg::HASH: begin
            if (stat.skip) begin
               state_in = skht_pkg::REPLY;
            end else if (stat.hash_done) begin
               state_in = skht_pkg::PROBE;
            end
         end
         skht_pkg::PROBE: begin
            if (stat.probe_done) state_in = skht_pkg::REPLY;
         end
         skht_pkg::REPLY: begin
            if (stat.out_free) state_in = skht_pkg::IDLE;
         end
         default: state_in = skht_pkg::IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         skht_pkg::IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         skht_pkg::HASH: begin
            cmd.hash_step   = !stat.skip && !stat.hash_done;
            cmd.probe_start = !stat.skip && stat.hash_done;
         end
         skht_pkg::PROBE: begin
            cmd.probe_eval = 1'b1;
         end
         skht_pkg::REPLY: begin
            cmd.reply_load = stat.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Only one item is in work at a time.
   `SKHT_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready)

endmodule

// File: hdl/skht_dp.sv
// Datapath of the string key hash table unit: key capture, hash fold, slot memory,
// occupied marks, probe compare and the result register.
// Depends on: skht_pkg, string_key_hash_table_unit_assert.svh.
`include "string_key_hash_table_unit_assert.svh"

module skht_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  skht_pkg::cmd_type                     cmd,
   output skht_pkg::stat_type                    stat,
   input  logic [skht_pkg::OP_W-1:0]             req_operation,
   input  logic [skht_pkg::KEY_FIELD_W-1:0]      req_key_bytes,
   input  logic [skht_pkg::LEN_FIELD_W-1:0]      req_key_length,
   input  logic [skht_pkg::VALUE_FIELD_W-1:0]    req_new_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [1:0]                            rsp_status,
   output logic [skht_pkg::VALUE_FIELD_W-1:0]    rsp_read_value
);

   localparam logic [skht_pkg::SLOT_W-1:0] LAST_SLOT =
      skht_pkg::SLOT_W'(skht_pkg::TABLE_SLOTS - 1);

   // Captured item.
   logic [skht_pkg::OP_W-1:0]                   op_ff;
   logic [skht_pkg::KEY_FIELD_BYTES-1:0][7:0]   key_ff;
   logic [skht_pkg::LEN_FIELD_W-1:0]            len_ff;
   logic [skht_pkg::STORE_VAL_W-1:0]            val_ff;
   logic                                        skip_ff;

   // Hash and probe state.
   logic [skht_pkg::LEN_FIELD_W-1:0] cnt_ff;
   logic [skht_pkg::SLOT_W-1:0]      h_ff;
   logic [skht_pkg::SLOT_W-1:0]      idx_ff;
   logic [skht_pkg::SLOT_W-1:0]      idx_in;
   logic [skht_pkg::SLOT_W-1:0]      steps_ff;

   // Pending result and the output register.
   skht_pkg::status_type             res_status_ff;
   logic [skht_pkg::VALUE_FIELD_W-1:0] res_value_ff;
   logic                             rsp_valid_ff;
   skht_pkg::status_type             rsp_status_ff;
   logic [skht_pkg::VALUE_FIELD_W-1:0] rsp_value_ff;

   // Slot memory and occupied marks.
   skht_pkg::entry_type              mem [skht_pkg::TABLE_SLOTS];
   skht_pkg::entry_type              rd_ff;
   logic [skht_pkg::TABLE_SLOTS-1:0] occ_ff;

   // Capture-side signals.
   logic [skht_pkg::LEN_FIELD_W-1:0]          limit;
   logic [skht_pkg::LEN_FIELD_W-1:0]          eff_len;
   logic                                      stop;
   logic [skht_pkg::KEY_FIELD_BYTES-1:0][7:0] key_prefix;

   // Probe-side signals.
   logic [skht_pkg::KEY_FIELD_W-1:0] key_flat;
   logic                             occ_hit;
   logic                             key_match;
   logic                             found;
   logic                             last_step;
   logic                             wr_en;
   logic                             clr_en;

   // Effective length: bytes before the first zero, capped by the length field and eight.
   always_comb begin
      limit   = (req_key_length > skht_pkg::LEN_FIELD_W'(skht_pkg::KEY_FIELD_BYTES)) ?
                skht_pkg::LEN_FIELD_W'(skht_pkg::KEY_FIELD_BYTES) : req_key_length;
      eff_len = '0;
      stop    = 1'b0;
      for (int i = 0; i < skht_pkg::KEY_FIELD_BYTES; i++) begin
         if (!stop && (skht_pkg::LEN_FIELD_W'(i) < limit) &&
             (req_key_bytes[8*i +: 8] != 8'd0)) begin
            eff_len = skht_pkg::LEN_FIELD_W'(i + 1);
         end else begin
            stop = 1'b1;
         end
      end
      for (int i = 0; i < skht_pkg::KEY_FIELD_BYTES; i++) begin
         key_prefix[i] = (skht_pkg::LEN_FIELD_W'(i) < eff_len) ? req_key_bytes[8*i +: 8] : 8'd0;
      end
   end

   // Item capture, with the early result for undefined operations and long keys.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_operation;
         key_ff  <= key_prefix;
         len_ff  <= eff_len;
         val_ff  <= req_new_value[skht_pkg::STORE_VAL_W-1:0];
         skip_ff <= (req_operation != skht_pkg::OP_SET) &&
                    (req_operation != skht_pkg::OP_GET) &&
                    (req_operation != skht_pkg::OP_REMOVE) ||
                    (eff_len >= skht_pkg::LEN_FIELD_W'(skht_pkg::KEY_BYTES));
      end
   end

   // Hash fold, one key byte per cycle.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cnt_ff <= '0;
         h_ff   <= '0;
      end else if (cmd.hash_step) begin
         cnt_ff <= cnt_ff + 1'b1;
         h_ff   <= skht_pkg::hash_step(h_ff, key_ff[cnt_ff[skht_pkg::BYTE_SEL_W-1:0]]);
      end
   end

   // Probe compare on the slot read in the previous cycle.
   assign key_flat  = key_ff;
   assign occ_hit   = occ_ff[idx_ff];
   assign key_match = (rd_ff.len == len_ff[skht_pkg::SLEN_W-1:0]) &&
                      (rd_ff.key == key_flat[skht_pkg::KEY_W-1:0]);
   assign found     = occ_hit && key_match;
   assign last_step = (steps_ff == LAST_SLOT);

   // Slot write and mark clear when a probe resolves.
   assign wr_en  = cmd.probe_eval && (op_ff == skht_pkg::OP_SET) && (!occ_hit || key_match);
   assign clr_en = cmd.probe_eval && (op_ff == skht_pkg::OP_REMOVE) && found;

   // Next probe index: the home slot at start, then one slot on with wrap.
   always_comb begin
      if (cmd.probe_start) begin
         idx_in = h_ff;
      end else if (cmd.probe_eval && !stat.probe_done) begin
         idx_in = (idx_ff == LAST_SLOT) ? '0 : idx_ff + 1'b1;
      end else begin
         idx_in = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.probe_start) begin
         steps_ff <= '0;
      end else if (cmd.probe_eval && !stat.probe_done) begin
         steps_ff <= steps_ff + 1'b1;
      end
   end

   // Slot memory: one write port, one registered read port that follows the probe index.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[idx_ff] <= '{key: key_flat[skht_pkg::KEY_W-1:0],
                          len: len_ff[skht_pkg::SLEN_W-1:0],
                          value: val_ff};
      end
      rd_ff <= mem[idx_in];
   end

   // Occupied marks, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else if (wr_en) begin
         occ_ff[idx_ff] <= 1'b1;
      end else if (clr_en) begin
         occ_ff[idx_ff] <= 1'b0;
      end
   end

   // Result of the item, set early at capture and final when the probe resolves.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_value_ff <= '0;
         if ((req_operation == skht_pkg::OP_SET) &&
             (eff_len >= skht_pkg::LEN_FIELD_W'(skht_pkg::KEY_BYTES))) begin
            res_status_ff <= skht_pkg::STATUS_TOO_LONG;
         end else begin
            res_status_ff <= skht_pkg::STATUS_NOT_FOUND;
         end
      end else if (cmd.probe_eval && stat.probe_done) begin
         res_value_ff <= '0;
         case (op_ff)
            skht_pkg::OP_SET: begin
               res_status_ff <= (!occ_hit || key_match) ? skht_pkg::STATUS_OK :
                                                          skht_pkg::STATUS_FULL;
            end
            skht_pkg::OP_GET: begin
               res_status_ff <= found ? skht_pkg::STATUS_OK : skht_pkg::STATUS_NOT_FOUND;
               if (found) res_value_ff <= skht_pkg::VALUE_FIELD_W'(rd_ff.value);
            end
            default: begin
               res_status_ff <= found ? skht_pkg::STATUS_OK : skht_pkg::STATUS_NOT_FOUND;
            end
         endcase
      end
   end

   // Output register: holds a result until it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.reply_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.reply_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_value_ff;

   // Status toward the controller.
   assign stat.skip       = skip_ff;
   assign stat.hash_done  = (cnt_ff == len_ff);
   assign stat.probe_done = !occ_hit || key_match || last_step;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   // A stored entry is marked occupied right after it is written.
   `SKHT_ASSERT_NEXT(a_write_marks, wr_en, occ_ff[$past(idx_ff)])
   // Only a successful get carries a value.
   `SKHT_ASSERT_NOW(a_value_on_ok, rsp_valid_ff && (rsp_value_ff != '0), rsp_status_ff == skht_pkg::STATUS_OK)
   // A new result never overwrites one that is still waiting.
   `SKHT_ASSERT_NOW(a_no_overwrite, cmd.reply_load, !rsp_valid_ff || rsp_ready)

endmodule

// File: hdl/string_key_hash_table_unit.sv
// Top level of the string key hash table unit: open-addressing map with short string keys.
// Depends on: skht_pkg, skht_ctrl, skht_dp.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_ready   operation, key_bytes, key_length, new_value
//   rsp_      out        rsp_valid/rsp_ready   status, read_value
//
// One item is in work at a time. An item passes from acceptance through the hash fold,
// which takes its key bytes in turn, then a probe start, then the probe, which visits
// one slot per cycle, limited by the registered read port of the slot memory, and
// then the reply, which waits until the output register is free.
// Undefined operations and long keys skip hash and probe and go straight to the reply.
// Reset clears the occupied marks at once; no clearing pass is needed.
// A result waits in the output register while the next item is accepted and hashed.

module string_key_hash_table_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [skht_pkg::OP_W-1:0]          req_operation,
   input  logic [skht_pkg::KEY_FIELD_W-1:0]   req_key_bytes,
   input  logic [skht_pkg::LEN_FIELD_W-1:0]   req_key_length,
   input  logic [skht_pkg::VALUE_FIELD_W-1:0] req_new_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic [skht_pkg::VALUE_FIELD_W-1:0] rsp_read_value
);

   skht_pkg::cmd_type  cmd;
   skht_pkg::stat_type stat;

   // Sequencer.
   skht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Storage, hash and compare.
   skht_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_operation  (req_operation),
      .req_key_bytes  (req_key_bytes),
      .req_key_length (req_key_length),
      .req_new_value  (req_new_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value)
   );

endmodule
